>>> design/ctrb_pkg.sv
// ----------------------------------------------------------------------------
// ctrb_pkg
// Shared types and constants for the clipped tile-rectangle blit row
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctrb_pkg;

	localparam int DEF_MAP_COLS    = 32;
	localparam int DEF_MAP_ROWS    = 24;
	localparam int DEF_NUM_BUFFERS = 8;

	// Width of the signed working values used while clipping.
	localparam int CLIP_W = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic clip;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic empty;
		logic final_row;
		logic slot_free;
	} sts_t;

endpackage

>>> design/ctrb_ctrl.sv
// ----------------------------------------------------------------------------
// ctrb_ctrl
// Request sequencer: takes a request, runs the clip step and then steps
// through the result transfers one per free output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ctrb_pkg::sts_t  sts,
	output ctrb_pkg::cmd_t  cmd
);

	ctrb_pkg::state_t state_q;
	ctrb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		unique case (state_q)
			ctrb_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid) begin
					state_d = ctrb_pkg::ST_CLIP;
				end
			end
			ctrb_pkg::ST_CLIP: begin
				cmd.clip = 1'b1;
				state_d  = ctrb_pkg::ST_EMIT;
			end
			ctrb_pkg::ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					if (sts.bad || sts.empty || sts.final_row) begin
						state_d = ctrb_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ctrb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/ctrb_datapath.sv
// ----------------------------------------------------------------------------
// ctrb_datapath
// Request registers, clipping arithmetic, row counters, dirty mask and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrb_datapath #(
	parameter int MAP_COLS    = ctrb_pkg::DEF_MAP_COLS,
	parameter int MAP_ROWS    = ctrb_pkg::DEF_MAP_ROWS,
	parameter int NUM_BUFFERS = ctrb_pkg::DEF_NUM_BUFFERS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrb_pkg::cmd_t     cmd,
	output ctrb_pkg::sts_t     sts,
	input  logic [4:0]         buffer_handle,
	input  logic signed [7:0]  dest_col,
	input  logic signed [7:0]  dest_row,
	input  logic [7:0]         src_col,
	input  logic [7:0]         src_row,
	input  logic signed [8:0]  req_width,
	input  logic signed [8:0]  req_height,
	input  logic [7:0]         map_width_tiles,
	input  logic [7:0]         map_height_tiles,
	input  logic               do_copy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               row_valid,
	output logic               bad_handle,
	output logic [2:0]         buffer_index,
	output logic [16:0]        src_offset,
	output logic [9:0]         dst_offset,
	output logic [5:0]         row_length,
	output logic               clear_row,
	output logic [7:0]         dirty_mask,
	output logic               last
);

	localparam int CW = ctrb_pkg::CLIP_W;
	localparam logic signed [CW-1:0] COLS_S = CW'(MAP_COLS);
	localparam logic signed [CW-1:0] ROWS_S = CW'(MAP_ROWS);
	localparam logic [3:0] NBUF = 4'(NUM_BUFFERS);

	logic                 bad_q;
	logic [2:0]           idx_q;
	logic                 copy_q;
	logic [7:0]           mapw_q;
	logic [8:0]           scol_q;
	logic [8:0]           srow_q;
	logic [6:0]           dcol_q;
	logic [6:0]           drow_q;
	logic signed [CW-1:0] w_q;
	logic signed [CW-1:0] rows_q;
	logic                 empty_q;
	logic [7:0]           dirty_q;
	logic                 out_valid_q;

	logic                 handle_ok;
	logic [2:0]           idx_d;
	logic signed [CW-1:0] wsel;
	logic signed [CW-1:0] hsel;
	logic signed [CW-1:0] col_sum;
	logic signed [CW-1:0] row_sum;
	logic signed [CW-1:0] w_clip;
	logic signed [CW-1:0] h_clip;
	logic [13:0]          drow_scaled;
	logic [9:0]           dst_d;
	logic [16:0]          src_d;

	assign handle_ok = buffer_handle[3] && !buffer_handle[2];
	assign idx_d     = {buffer_handle[4], buffer_handle[1:0]};

	assign wsel = (req_width == -9'sd1) ? $signed({3'b000, map_width_tiles})
		: CW'(req_width);
	assign hsel = (req_height == -9'sd1) ? $signed({3'b000, map_height_tiles})
		: CW'(req_height);

	assign col_sum = $signed({4'b0000, dcol_q}) + w_q;
	assign row_sum = $signed({4'b0000, drow_q}) + rows_q;
	assign w_clip  = (col_sum > COLS_S) ? COLS_S - $signed({4'b0000, dcol_q}) : w_q;
	assign h_clip  = (row_sum > ROWS_S) ? ROWS_S - $signed({4'b0000, drow_q}) : rows_q;

	assign drow_scaled = 14'(drow_q) * 14'(MAP_COLS);
	assign dst_d       = 10'(14'(dcol_q) + drow_scaled);
	assign src_d       = 17'(mapw_q) * 17'(srow_q) + 17'(scol_q);

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			bad_q  <= !handle_ok || ({1'b0, idx_d} >= NBUF);
			idx_q  <= idx_d;
			copy_q <= do_copy;
			mapw_q <= map_width_tiles;
			if (dest_col[7]) begin
				w_q    <= wsel + CW'(dest_col);
				scol_q <= {1'b0, src_col} - 9'(dest_col);
				dcol_q <= '0;
			end else begin
				w_q    <= wsel;
				scol_q <= {1'b0, src_col};
				dcol_q <= dest_col[6:0];
			end
			if (dest_row[7]) begin
				rows_q <= hsel + CW'(dest_row);
				srow_q <= {1'b0, src_row} - 9'(dest_row);
				drow_q <= '0;
			end else begin
				rows_q <= hsel;
				srow_q <= {1'b0, src_row};
				drow_q <= dest_row[6:0];
			end
		end else if (cmd.clip) begin
			w_q     <= w_clip;
			rows_q  <= h_clip;
			empty_q <= (w_clip <= 0) || (h_clip <= 0);
		end else if (cmd.emit && !bad_q && !empty_q) begin
			rows_q <= rows_q - CW'(1);
			srow_q <= srow_q + 9'd1;
			drow_q <= drow_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clip && !bad_q) begin
				dirty_q <= dirty_q | (8'd1 << idx_q);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dirty_mask <= dirty_q;
			priority if (bad_q) begin
				row_valid    <= 1'b0;
				bad_handle   <= 1'b1;
				buffer_index <= '0;
				src_offset   <= '0;
				dst_offset   <= '0;
				row_length   <= '0;
				clear_row    <= 1'b0;
				last         <= 1'b1;
			end else if (empty_q) begin
				row_valid    <= 1'b0;
				bad_handle   <= 1'b0;
				buffer_index <= idx_q;
				src_offset   <= '0;
				dst_offset   <= '0;
				row_length   <= '0;
				clear_row    <= 1'b0;
				last         <= 1'b1;
			end else begin
				row_valid    <= 1'b1;
				bad_handle   <= 1'b0;
				buffer_index <= idx_q;
				src_offset   <= copy_q ? src_d : '0;
				dst_offset   <= dst_d;
				row_length   <= w_q[5:0];
				clear_row    <= !copy_q;
				last         <= (rows_q == CW'(1));
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sts.bad       = bad_q;
	assign sts.empty     = empty_q;
	assign sts.final_row = (rows_q == CW'(1));
	assign sts.slot_free = !out_valid_q || out_ready;

endmodule

>>> design/clipped_tile_rect_blit_rows_core.sv
// ----------------------------------------------------------------------------
// clipped_tile_rect_blit_rows_core
// Clips a tile-rectangle request to the destination map and issues one row
// command per remaining row, keeping a mask of the buffers that were touched.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Carries
//  request   in         in_valid / in_ready   one rectangle request
//  result    out        out_valid / out_ready one row command or status result
//
// A request is clipped in the cycle after it is taken; its results then
// leave one per cycle from the single output register while the output side
// does not stall: one row command per row, or a single status result for a
// bad handle or an empty rectangle. A stall on the output holds the current
// transfer and the row counters. Reset clears the sequencer, the output valid
// and the dirty mask.
`timescale 1ns / 1ps

module clipped_tile_rect_blit_rows_core #(
	parameter int MAP_COLS    = ctrb_pkg::DEF_MAP_COLS,
	parameter int MAP_ROWS    = ctrb_pkg::DEF_MAP_ROWS,
	parameter int NUM_BUFFERS = ctrb_pkg::DEF_NUM_BUFFERS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         buffer_handle,
	input  logic signed [7:0]  dest_col,
	input  logic signed [7:0]  dest_row,
	input  logic [7:0]         src_col,
	input  logic [7:0]         src_row,
	input  logic signed [8:0]  req_width,
	input  logic signed [8:0]  req_height,
	input  logic [7:0]         map_width_tiles,
	input  logic [7:0]         map_height_tiles,
	input  logic               do_copy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               row_valid,
	output logic               bad_handle,
	output logic [2:0]         buffer_index,
	output logic [16:0]        src_offset,
	output logic [9:0]         dst_offset,
	output logic [5:0]         row_length,
	output logic               clear_row,
	output logic [7:0]         dirty_mask,
	output logic               last
);

	ctrb_pkg::cmd_t cmd;
	ctrb_pkg::sts_t sts;

	ctrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctrb_datapath #(
		.MAP_COLS    (MAP_COLS),
		.MAP_ROWS    (MAP_ROWS),
		.NUM_BUFFERS (NUM_BUFFERS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.buffer_handle    (buffer_handle),
		.dest_col         (dest_col),
		.dest_row         (dest_row),
		.src_col          (src_col),
		.src_row          (src_row),
		.req_width        (req_width),
		.req_height       (req_height),
		.map_width_tiles  (map_width_tiles),
		.map_height_tiles (map_height_tiles),
		.do_copy          (do_copy),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.row_valid        (row_valid),
		.bad_handle       (bad_handle),
		.buffer_index     (buffer_index),
		.src_offset       (src_offset),
		.dst_offset       (dst_offset),
		.row_length       (row_length),
		.clear_row        (clear_row),
		.dirty_mask       (dirty_mask),
		.last             (last)
	);

endmodule

>>> design/ctrb_checker.sv
// ----------------------------------------------------------------------------
// ctrb_checker
// Port-level checks on the result channel of the blit row generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctrb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        row_valid,
	input logic        bad_handle,
	input logic [16:0] src_offset,
	input logic        clear_row,
	input logic [7:0]  dirty_mask,
	input logic        last
);

	// A stalled transfer keeps its row command.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(src_offset) && $stable(last))
		else $error("result changed while stalled");

	// A result without a row command is always the only one of its request.
	a_norow_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !row_valid |-> last)
		else $error("status result not marked last");

	a_bad_norow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_handle |-> !row_valid)
		else $error("bad handle result carries a row");

	// Buffers once marked dirty stay marked.
	a_mask_grows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |->
			((dirty_mask & $past(dirty_mask)) == $past(dirty_mask)))
		else $error("dirty mask lost a bit");

	a_clear_src: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && row_valid && clear_row |-> src_offset == 17'd0)
		else $error("clear row with non-zero source offset");

endmodule

bind clipped_tile_rect_blit_rows_core ctrb_checker u_ctrb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.row_valid  (row_valid),
	.bad_handle (bad_handle),
	.src_offset (src_offset),
	.clear_row  (clear_row),
	.dirty_mask (dirty_mask),
	.last       (last)
);
